/* hdl/rtpj_pkg.sv */
`default_nettype none

package rtpj_pkg;

    localparam int unsigned RATE_W   = 24;
    localparam int unsigned TS_W     = 32;
    localparam int unsigned ARR_W    = 64;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned JIT_W    = 32;
    localparam int unsigned ACC_W    = 48;
    localparam int unsigned PC_W     = 4;
    localparam int unsigned CNT_W    = 7;
    localparam int unsigned CDIV_W   = 14;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_NOT_CONFIGURED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRIMED         = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FRAGMENT       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_GAP_TOO_LARGE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UPDATED        = 3'd4;

    localparam logic [TS_W-1:0]   MAX_STEP  = 32'h00FF_FFFF;
    localparam logic [RATE_W-1:0] NS_PER_MS = 24'd1000000;
    localparam logic [9:0]        MS_PER_S  = 10'd1000;

    // constant divides by reciprocal multiply, one 16-bit digit per pass;
    // ns to ms is a shift by 6 and then a divide by 15625
    localparam int unsigned       NS_SHIFT      = 6;
    localparam logic [CDIV_W-1:0] NS_ODD_DIV    = 14'd15625;
    localparam logic [30:0]       NS_RECIP      = 31'd1125899907;
    localparam int unsigned       NS_RECIP_SH   = 44;
    localparam logic [CDIV_W-1:0] MEAN_DIV      = 14'd10;
    localparam logic [30:0]       MEAN_RECIP    = 31'd1677722;
    localparam int unsigned       MEAN_RECIP_SH = 24;

    // loop counts: digits of a constant divide, quotient bits of the scaled step
    localparam logic [CNT_W-1:0] DIV_C_DIGITS = 7'd4;
    localparam logic [CNT_W-1:0] DIV_T_BITS   = 7'd34;

    // datapath operations
    localparam logic [3:0] OP_LOAD_A  = 4'd0;
    localparam logic [3:0] OP_DIV     = 4'd1;
    localparam logic [3:0] OP_SAVE_A  = 4'd2;
    localparam logic [3:0] OP_LOAD_T  = 4'd3;
    localparam logic [3:0] OP_SUB_T   = 4'd4;
    localparam logic [3:0] OP_SAT_J   = 4'd5;
    localparam logic [3:0] OP_MIX     = 4'd6;
    localparam logic [3:0] OP_LOAD_M  = 4'd7;
    localparam logic [3:0] OP_SAVE_M  = 4'd8;
    localparam logic [3:0] OP_RECIP_Q = 4'd9;
    localparam logic [3:0] OP_RECIP_R = 4'd10;

    // sequencing conditions
    localparam logic [1:0] C_NEXT = 2'd0;
    localparam logic [1:0] C_LOOP = 2'd1;
    localparam logic [1:0] C_END  = 2'd2;

    localparam logic [PC_W-1:0] PC_LAST = 4'd12;

    typedef struct packed {
        logic [3:0]      op;
        logic [1:0]      cond;
        logic [PC_W-1:0] target;
    } t_uword;

    function automatic t_uword uop_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            4'd0:    w = '{op: OP_LOAD_A,  cond: C_NEXT, target: 4'd0};
            4'd1:    w = '{op: OP_RECIP_Q, cond: C_NEXT, target: 4'd0};
            4'd2:    w = '{op: OP_RECIP_R, cond: C_LOOP, target: 4'd1};
            4'd3:    w = '{op: OP_SAVE_A,  cond: C_NEXT, target: 4'd0};
            4'd4:    w = '{op: OP_LOAD_T,  cond: C_NEXT, target: 4'd0};
            4'd5:    w = '{op: OP_DIV,     cond: C_LOOP, target: 4'd5};
            4'd6:    w = '{op: OP_SUB_T,   cond: C_NEXT, target: 4'd0};
            4'd7:    w = '{op: OP_SAT_J,   cond: C_NEXT, target: 4'd0};
            4'd8:    w = '{op: OP_MIX,     cond: C_NEXT, target: 4'd0};
            4'd9:    w = '{op: OP_LOAD_M,  cond: C_NEXT, target: 4'd0};
            4'd10:   w = '{op: OP_RECIP_Q, cond: C_NEXT, target: 4'd0};
            4'd11:   w = '{op: OP_RECIP_R, cond: C_LOOP, target: 4'd10};
            4'd12:   w = '{op: OP_SAVE_M,  cond: C_END,  target: 4'd0};
            default: w = '{op: OP_SAVE_M,  cond: C_END,  target: 4'd0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* hdl/rtp_jitter_estimator.sv */
// rtp interarrival jitter estimator
//
// input channel (i_in_valid / o_in_ready) takes one word per packet: rtp timestamp and
// arrival time in ns. output channel (o_out_valid / i_out_ready) gives one word per
// packet: status, jitter and mean jitter in ms. i_cfg_we writes the clock rate and
// clears all estimator state; write it only while the block is idle.
//
// a packet that is not configured, primes state, is a fragment or has too large a
// timestamp gap is answered in the cycle after acceptance. an update runs a microcoded
// program of 13 steps: the arrival delta and the mean are divided by their constants
// with a reciprocal multiply, one 16-bit quotient digit per pass over 4 digits, and the
// scaled timestamp step by the rate in a restoring divider, one bit per cycle over 34
// bits; the next packet can be taken in the cycle the result is read.
//
// synchronous reset clears the rate (not configured), the state and the output valid flag.
// the input is taken only when the output register is empty or being read, so a
// stalled receiver holds back the next packet; a result waits in the output register.

`default_nettype none

module rtp_jitter_estimator
    import rtpj_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire  [RATE_W-1:0]        i_cfg_data,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire  [TS_W-1:0]          i_rtp_timestamp,
    input  wire  [ARR_W-1:0]         i_arrival_ns,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic signed [JIT_W-1:0]  o_jitter_ms,
    output logic signed [JIT_W-1:0]  o_mean_jitter_ms
);

    function automatic logic signed [JIT_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = 48'sh0000_7FFF_FFFF;
        lo = 48'shFFFF_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[JIT_W-1:0];
    endfunction

    // control and state
    logic [RATE_W-1:0]        r_rate,      n_rate;
    logic                     r_primed,    n_primed;
    logic [TS_W-1:0]          r_last_ts,   n_last_ts;
    logic [ARR_W-1:0]         r_last_arr,  n_last_arr;
    logic signed [JIT_W-1:0]  r_jitter,    n_jitter;
    logic signed [JIT_W-1:0]  r_mean,      n_mean;
    logic                     r_busy,      n_busy;
    logic [PC_W-1:0]          r_pc,        n_pc;
    logic                     r_out_valid, n_out_valid;

    // datapath
    logic [CNT_W-1:0]         r_cnt,        n_cnt;
    logic [ARR_W-1:0]         r_num,        n_num;
    logic [RATE_W-1:0]        r_rem,        n_rem;
    logic [RATE_W-1:0]        r_den,        n_den;
    logic [15:0]              r_q,          n_q;
    logic                     r_csel,       n_csel;
    logic signed [ACC_W-1:0]  r_acc,        n_acc;
    logic                     r_neg,        n_neg;
    logic [RATE_W-1:0]        r_step,       n_step;
    logic [ARR_W-1:0]         r_adelta,     n_adelta;
    logic [STATUS_W-1:0]      r_out_status, n_out_status;
    logic signed [JIT_W-1:0]  r_out_jitter, n_out_jitter;
    logic signed [JIT_W-1:0]  r_out_mean,   n_out_mean;

    t_uword                   w_uw;
    logic                     w_accept;
    logic [TS_W-1:0]          w_step;
    logic [RATE_W:0]          w_rem_sh;
    logic [RATE_W+1:0]        w_diff;
    logic                     w_qbit;
    logic [29:0]              w_cv;
    logic [30:0]              w_crecip;
    logic [CDIV_W-1:0]        w_cden;
    logic [60:0]              w_cprod;
    logic [15:0]              w_cq;
    logic [29:0]              w_cqd;
    logic [29:0]              w_crem;
    logic [33:0]              w_prod;
    logic signed [ACC_W-1:0]  w_mean_x;
    logic signed [ACC_W-1:0]  w_jit_x;
    logic signed [ACC_W-1:0]  w_mag;
    logic signed [ACC_W-1:0]  w_mq;
    logic signed [ACC_W-1:0]  w_mval;
    logic signed [JIT_W-1:0]  w_mean_sat;

    assign w_uw       = uop_rom(r_pc);
    assign o_in_ready = !r_busy && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_step     = i_rtp_timestamp - r_last_ts;

    // restoring divider, one quotient bit per cycle shifted into the low end of r_num
    assign w_rem_sh = {r_rem, r_num[ARR_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_den};
    assign w_qbit   = !w_diff[RATE_W+1];

    // constant divide: remainder and top 16-bit digit, quotient digit by reciprocal
    assign w_cv     = {r_rem[CDIV_W-1:0], r_num[ARR_W-1 -: 16]};
    assign w_crecip = r_csel ? MEAN_RECIP : NS_RECIP;
    assign w_cden   = r_csel ? MEAN_DIV : NS_ODD_DIV;
    assign w_cprod  = 61'(w_cv) * 61'(w_crecip);
    assign w_cq     = r_csel ? w_cprod[MEAN_RECIP_SH +: 16] : w_cprod[NS_RECIP_SH +: 16];
    assign w_cqd    = 30'(r_q) * 30'(w_cden);
    assign w_crem   = w_cv - w_cqd;

    assign w_prod     = 34'(r_step) * 34'(MS_PER_S);
    assign w_mean_x   = ACC_W'(r_mean);
    assign w_jit_x    = ACC_W'(r_jitter);
    assign w_mag      = r_acc[ACC_W-1] ? -r_acc : r_acc;
    assign w_mq       = $signed({12'd0, r_num[35:0]});
    assign w_mval     = r_neg ? -w_mq : w_mq;
    assign w_mean_sat = sat32(w_mval);

    always_comb begin
        n_rate       = r_rate;
        n_primed     = r_primed;
        n_last_ts    = r_last_ts;
        n_last_arr   = r_last_arr;
        n_jitter     = r_jitter;
        n_mean       = r_mean;
        n_busy       = r_busy;
        n_pc         = r_pc;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_cnt        = r_cnt;
        n_num        = r_num;
        n_rem        = r_rem;
        n_den        = r_den;
        n_q          = r_q;
        n_csel       = r_csel;
        n_acc        = r_acc;
        n_neg        = r_neg;
        n_step       = r_step;
        n_adelta     = r_adelta;
        n_out_status = r_out_status;
        n_out_jitter = r_out_jitter;
        n_out_mean   = r_out_mean;

        if (i_cfg_we) begin
            n_rate     = i_cfg_data;
            n_primed   = 1'b0;
            n_last_ts  = '0;
            n_last_arr = '0;
            n_jitter   = '0;
            n_mean     = '0;
        end else if (w_accept) begin
            n_out_jitter = r_jitter;
            n_out_mean   = r_mean;
            n_out_valid  = 1'b1;
            if (r_rate == '0) begin
                n_out_status = ST_NOT_CONFIGURED;
            end else if (!r_primed) begin
                n_primed     = 1'b1;
                n_last_ts    = i_rtp_timestamp;
                n_last_arr   = i_arrival_ns;
                n_out_status = ST_PRIMED;
            end else if (i_rtp_timestamp == r_last_ts) begin
                n_out_status = ST_FRAGMENT;
            end else begin
                n_last_ts  = i_rtp_timestamp;
                n_last_arr = i_arrival_ns;
                if (w_step > MAX_STEP) begin
                    n_out_status = ST_GAP_TOO_LARGE;
                end else begin
                    // result comes from the program; output slot is free by then
                    n_out_valid = 1'b0;
                    n_busy      = 1'b1;
                    n_pc        = '0;
                    n_step      = w_step[RATE_W-1:0];
                    n_adelta    = i_arrival_ns - r_last_arr;
                end
            end
        end else if (r_busy) begin
            case (w_uw.op)
                OP_LOAD_A: begin
                    n_num  = r_adelta >> NS_SHIFT;
                    n_rem  = '0;
                    n_csel = 1'b0;
                    n_cnt  = DIV_C_DIGITS;
                end
                OP_RECIP_Q: begin
                    n_q = w_cq;
                end
                OP_RECIP_R: begin
                    n_rem = RATE_W'(w_crem[CDIV_W-1:0]);
                    n_num = {r_num[ARR_W-17:0], r_q};
                    n_cnt = r_cnt - 1'b1;
                end
                OP_DIV: begin
                    n_rem = w_qbit ? w_diff[RATE_W-1:0] : w_rem_sh[RATE_W-1:0];
                    n_num = {r_num[ARR_W-2:0], w_qbit};
                    n_cnt = r_cnt - 1'b1;
                end
                OP_SAVE_A: begin
                    n_acc = $signed({3'd0, r_num[44:0]});
                end
                OP_LOAD_T: begin
                    n_num = {w_prod, 30'd0};
                    n_den = r_rate;
                    n_rem = '0;
                    n_cnt = DIV_T_BITS;
                end
                OP_SUB_T: begin
                    n_acc = r_acc - $signed({14'd0, r_num[33:0]});
                end
                OP_SAT_J: begin
                    n_jitter = sat32(r_acc);
                end
                OP_MIX: begin
                    n_acc = (w_mean_x <<< 3) + w_mean_x + w_jit_x;
                end
                OP_LOAD_M: begin
                    // divide the magnitude, truncating toward zero
                    n_neg  = r_acc[ACC_W-1];
                    n_num  = ARR_W'(w_mag[35:0]);
                    n_rem  = '0;
                    n_csel = 1'b1;
                    n_cnt  = DIV_C_DIGITS;
                end
                OP_SAVE_M: begin
                    n_mean       = w_mean_sat;
                    n_out_valid  = 1'b1;
                    n_out_status = ST_UPDATED;
                    n_out_jitter = r_jitter;
                    n_out_mean   = w_mean_sat;
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase

            case (w_uw.cond)
                C_LOOP: begin
                    if (r_cnt != CNT_W'(1)) begin
                        n_pc = w_uw.target;
                    end else begin
                        n_pc = r_pc + 1'b1;
                    end
                end
                C_END: begin
                    n_busy = 1'b0;
                    n_pc   = '0;
                end
                default: begin
                    n_pc = r_pc + 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= '0;
            r_primed    <= 1'b0;
            r_last_ts   <= '0;
            r_last_arr  <= '0;
            r_jitter    <= '0;
            r_mean      <= '0;
            r_busy      <= 1'b0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rate      <= n_rate;
            r_primed    <= n_primed;
            r_last_ts   <= n_last_ts;
            r_last_arr  <= n_last_arr;
            r_jitter    <= n_jitter;
            r_mean      <= n_mean;
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_num        <= n_num;
        r_rem        <= n_rem;
        r_den        <= n_den;
        r_q          <= n_q;
        r_csel       <= n_csel;
        r_acc        <= n_acc;
        r_neg        <= n_neg;
        r_step       <= n_step;
        r_adelta     <= n_adelta;
        r_out_status <= n_out_status;
        r_out_jitter <= n_out_jitter;
        r_out_mean   <= n_out_mean;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_jitter_ms      = r_out_jitter;
    assign o_mean_jitter_ms = r_out_mean;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && w_uw.op == OP_DIV |-> r_rem < r_den)
        else $error("divider remainder not below divisor");

    a_digit_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && w_uw.op == OP_RECIP_Q |-> r_rem < RATE_W'(w_cden))
        else $error("constant divide remainder not below divisor");

    a_div_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && (w_uw.op == OP_DIV || w_uw.op == OP_RECIP_R) |-> r_cnt != '0)
        else $error("divide step entered with zero count");

    a_program_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_pc == PC_LAST |=> o_out_valid && o_status == ST_UPDATED && !r_busy)
        else $error("program end did not deliver an update");

    a_unconfigured_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !i_cfg_we && r_rate == '0 |=>
            o_out_valid && o_status == ST_NOT_CONFIGURED && !r_busy)
        else $error("unconfigured packet not answered at once");

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench
    import rtpj_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned DRAIN_WAIT  = 160;

    typedef struct {
        logic [STATUS_W-1:0]     status;
        logic signed [JIT_W-1:0] jitter;
        logic signed [JIT_W-1:0] mean;
    } t_jitter_report;

    // tracks the estimator state and holds the reports still owed by the block
    class t_jitter_tracker;
        logic [RATE_W-1:0]       rate;
        bit                      primed;
        logic [TS_W-1:0]         last_ts;
        logic [ARR_W-1:0]        last_arr;
        logic signed [JIT_W-1:0] jit_now;
        logic signed [JIT_W-1:0] mean_now;
        t_jitter_report          expected_reports[$];
        int unsigned             mismatches;
        int unsigned             checked;
        int unsigned             status_seen[8];

        function void set_rate(input logic [RATE_W-1:0] value);
            rate     = value;
            primed   = 1'b0;
            last_ts  = '0;
            last_arr = '0;
            jit_now  = '0;
            mean_now = '0;
        endfunction

        function logic signed [JIT_W-1:0] clamp_ms(input longint v);
            if (v > 64'sd2147483647)
                return 32'sh7FFF_FFFF;
            if (v < -64'sd2147483648)
                return 32'sh8000_0000;
            return JIT_W'(v);
        endfunction

        function void predict_packet(input logic [TS_W-1:0] ts, input logic [ARR_W-1:0] arr);
            t_jitter_report   rep;
            logic [TS_W-1:0]  step;
            logic [ARR_W-1:0] adelta;
            longint           rcv_ms;
            longint           ts_ms;
            longint           mix;
            if (rate == '0) begin
                rep.status = ST_NOT_CONFIGURED;
            end else if (!primed) begin
                primed     = 1'b1;
                last_ts    = ts;
                last_arr   = arr;
                rep.status = ST_PRIMED;
            end else if (ts == last_ts) begin
                rep.status = ST_FRAGMENT;
            end else begin
                step     = ts - last_ts;
                adelta   = arr - last_arr;
                last_ts  = ts;
                last_arr = arr;
                if (step > MAX_STEP) begin
                    rep.status = ST_GAP_TOO_LARGE;
                end else begin
                    rcv_ms   = longint'(adelta / 64'(NS_PER_MS));
                    ts_ms    = longint'((64'(step) * 64'(MS_PER_S)) / 64'(rate));
                    jit_now  = clamp_ms(rcv_ms - ts_ms);
                    mix      = 9 * longint'(mean_now) + longint'(jit_now);
                    mean_now = clamp_ms(mix / 10);
                    rep.status = ST_UPDATED;
                end
            end
            rep.jitter = jit_now;
            rep.mean   = mean_now;
            expected_reports.push_back(rep);
        endfunction

        function void compare_report(input logic [STATUS_W-1:0] status,
                                     input logic signed [JIT_W-1:0] jitter,
                                     input logic signed [JIT_W-1:0] mean_jit);
            t_jitter_report want;
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected word status %0d jitter %0d mean %0d",
                             status, jitter, mean_jit);
                return;
            end
            want = expected_reports.pop_front();
            checked++;
            status_seen[want.status]++;
            if (status !== want.status || jitter !== want.jitter || mean_jit !== want.mean) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: mismatch #%0d exp status %0d jitter %0d mean %0d, got %0d %0d %0d",
                             checked, want.status, want.jitter, want.mean,
                             status, jitter, mean_jit);
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [RATE_W-1:0]       i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [TS_W-1:0]         i_rtp_timestamp = '0;
    logic [ARR_W-1:0]        i_arrival_ns = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [STATUS_W-1:0]     o_status;
    logic signed [JIT_W-1:0] o_jitter_ms;
    logic signed [JIT_W-1:0] o_mean_jitter_ms;

    t_jitter_tracker  tracker;
    int unsigned      cycle_count = 0;
    int unsigned      packets_sent = 0;
    int unsigned      rates_written = 0;
    logic [RATE_W-1:0] cur_rate = '0;
    logic [TS_W-1:0]  gen_ts;
    logic [ARR_W-1:0] gen_arr;
    int unsigned      ready_mode = 0;
    int unsigned      ready_age = 0;
    int unsigned      stall_left = 0;

    rtp_jitter_estimator uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rtp_timestamp  (i_rtp_timestamp),
        .i_arrival_ns     (i_arrival_ns),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_jitter_ms      (o_jitter_ms),
        .o_mean_jitter_ms (o_mean_jitter_ms)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.compare_report(o_status, o_jitter_ms, o_mean_jitter_ms);
    end

    // receiver: switches between always ready, coin flips, long stalls and mostly stalled
    always @(negedge i_clk) begin
        logic next_ready;
        if (ready_age == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_age  = 400;
        end else begin
            ready_age--;
        end
        case (ready_mode)
            0: begin
                next_ready = 1'b1;
            end
            1: begin
                next_ready = 1'($urandom_range(0, 1));
            end
            2: begin
                if (stall_left > 0) begin
                    stall_left--;
                    next_ready = 1'b0;
                end else begin
                    if ($urandom_range(0, 29) == 0)
                        stall_left = $urandom_range(1, 80);
                    next_ready = 1'b1;
                end
            end
            default: begin
                next_ready = ($urandom_range(0, 3) == 0);
            end
        endcase
        i_out_ready = next_ready;
    end

    task automatic send_packet(input logic [TS_W-1:0] ts, input logic [ARR_W-1:0] arr);
        @(negedge i_clk);
        i_in_valid      = 1'b1;
        i_rtp_timestamp = ts;
        i_arrival_ns    = arr;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.predict_packet(ts, arr);
        packets_sent++;
    endtask

    task automatic pause_sender(input int unsigned gap);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        repeat (gap) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.expected_reports.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        tracker.set_rate(value);
        cur_rate = value;
        rates_written++;
    endtask

    // mostly a plausible media stream at the current rate, with fragments, big gaps,
    // clock steps backward and plain noise mixed in
    task automatic send_stream_packet();
        int unsigned      pick;
        logic [TS_W-1:0]  frame;
        logic [TS_W-1:0]  step;
        logic [ARR_W-1:0] eff_rate;
        longint           noise;
        pick     = $urandom_range(0, 99);
        eff_rate = (cur_rate == '0) ? 64'd8000 : 64'(cur_rate);
        frame    = (eff_rate / 50 == 0) ? 32'd1 : TS_W'(eff_rate / 50);
        step     = frame + $urandom_range(0, frame / 4);
        noise    = longint'($urandom_range(0, 60_000_000)) - 64'sd30_000_000;
        if (pick < 70) begin
            gen_ts  = gen_ts + step;
            gen_arr = gen_arr + (64'(step) * 64'd1_000_000_000) / eff_rate + 64'(noise);
        end else if (pick < 78) begin
            gen_arr = gen_arr + 64'($urandom_range(0, 2_000_000));
        end else if (pick < 82) begin
            gen_ts  = gen_ts + $urandom_range(32'h0100_0000, 32'hFFFF_FFFF);
            gen_arr = gen_arr + 64'($urandom_range(0, 32'hFFFF_FFFF));
        end else if (pick < 86) begin
            gen_ts  = gen_ts + step;
            gen_arr = gen_arr - 64'($urandom_range(1, 1_000_000_000));
        end else if (pick < 94) begin
            gen_ts  = gen_ts + $urandom_range(1, MAX_STEP);
            gen_arr = gen_arr + 64'($urandom) * 64'($urandom_range(1, 1000));
        end else begin
            gen_ts  = $urandom;
            gen_arr = {$urandom, $urandom};
        end
        send_packet(gen_ts, gen_arr);
    endtask

    initial begin
        logic [RATE_W-1:0] phase_rates[9];
        int unsigned       count;
        int unsigned       burst_left;
        bit                no_idle;

        tracker = new();
        tracker.set_rate('0);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // not configured after reset
        send_packet(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_packet(32'h0000_0000, 64'h0);

        write_rate(24'd8000);
        send_packet(32'd0, 64'd0);
        send_packet(32'd0, 64'd5_000_000);
        send_packet(32'd160, 64'd20_000_000);
        // step of exactly the largest allowed size
        send_packet(32'h0100_009F, 64'd40_000_000);
        send_packet(32'h0200_00A0, 64'd60_000_000);
        send_packet(32'hFFFF_FFF0, 64'd80_000_000);
        // timestamp wraps through zero
        send_packet(32'h0000_0010, 64'd84_000_000);
        // arrival goes backward, jitter saturates high
        send_packet(32'h0000_00B0, 64'd1_000);

        write_rate(24'd1);
        send_packet(32'd0, 64'd0);
        // huge expected interval, jitter saturates low
        send_packet(32'h00FF_FFFF, 64'd0);
        send_packet(32'h0100_0000, 64'd1_000_000_000);

        write_rate(24'hFF_FFFF);
        send_packet(32'h8000_0000, 64'hFFFF_FFFF_0000_0000);
        send_packet(32'h8000_0001, 64'hFFFF_FFFF_FFFF_FFFF);
        send_packet(32'h7FFF_FFFF, 64'h0000_0000_FFFF_FFFF);

        write_rate(24'd0);
        send_packet(32'h1234_5678, 64'h0);

        phase_rates[0] = 24'd8000;
        phase_rates[1] = 24'd90000;
        phase_rates[2] = 24'd48000;
        phase_rates[3] = 24'd1;
        phase_rates[4] = 24'hFF_FFFF;
        phase_rates[5] = RATE_W'($urandom_range(1, 24'hFF_FFFF));
        phase_rates[6] = 24'd0;
        phase_rates[7] = 24'd16000;
        phase_rates[8] = RATE_W'($urandom_range(2, 200000));

        for (int p = 0; p < 9; p++) begin
            write_rate(phase_rates[p]);
            gen_ts     = $urandom;
            gen_arr    = (p % 2 == 1) ? {$urandom, $urandom} : 64'($urandom);
            no_idle    = (p % 3 == 1);
            burst_left = $urandom_range(1, 12);
            count      = (phase_rates[p] == '0) ? 30 : 165;
            for (int n = 0; n < count; n++) begin
                // hold the sender until the block has answered everything
                if (n == count / 2 && p % 2 == 0)
                    wait_drained();
                send_stream_packet();
                if (!no_idle) begin
                    burst_left--;
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 7) == 0)
                            pause_sender($urandom_range(20, 160));
                        else
                            pause_sender($urandom_range(1, 6));
                        burst_left = $urandom_range(1, 12);
                    end
                end
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("tb: %0d packets sent, %0d results checked across %0d rate settings",
                 packets_sent, tracker.checked, rates_written);
        $display("tb: unset %0d, primed %0d, fragment %0d, gap %0d, updated %0d",
                 tracker.status_seen[ST_NOT_CONFIGURED], tracker.status_seen[ST_PRIMED],
                 tracker.status_seen[ST_FRAGMENT], tracker.status_seen[ST_GAP_TOO_LARGE],
                 tracker.status_seen[ST_UPDATED]);
        if (tracker.mismatches == 0 && tracker.expected_reports.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
